@@ rtl/rbb_pkg.sv @@
package rbb_pkg;

	localparam int COORD_W           = 32;
	localparam int TRIG_W            = 16;
	localparam int KW                = TRIG_W + 1;
	localparam int TRIG_FRACTION_DEF = 14;
	localparam int QUEUE_DEPTH       = 2;
	localparam int LANES             = 3;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = TRIG_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic signed [KW-1:0]      coef_t;

	localparam trig_t COSINE_RESET = trig_t'(16384);

	typedef enum logic [1:0] {
		AXIS_ROLL  = 2'd0,
		AXIS_PITCH = 2'd1,
		AXIS_YAW   = 2'd2,
		AXIS_NONE  = 2'd3
	} axis_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS   = 2'd0,
		REG_SINE   = 2'd1,
		REG_COSINE = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic   box_present;
		coord_t low_x;
		coord_t low_y;
		coord_t low_z;
		coord_t high_x;
		coord_t high_y;
		coord_t high_z;
	} box_t;

	typedef struct packed {
		logic   result_present;
		coord_t bound_low_x;
		coord_t bound_low_y;
		coord_t bound_low_z;
		coord_t bound_high_x;
		coord_t bound_high_y;
		coord_t bound_high_z;
	} bound_t;

	typedef struct packed {
		logic   pass;
		coord_t a_lo;
		coord_t a_hi;
		coord_t b_lo;
		coord_t b_hi;
		coef_t  ka;
		coef_t  kb;
	} lane_t;

	typedef struct packed {
		logic                  present;
		lane_t [LANES-1:0]     lane;
	} entry_t;

endpackage

@@ rtl/rbb_queue.sv @@
module rbb_queue import rbb_pkg::*; #(
	parameter int WIDTH = $bits(entry_t),
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/rbb_front.sv @@
module rbb_front import rbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  box_t                  box,
	output entry_t                entry
);

	axis_t axis_q;
	trig_t sine_q;
	trig_t cosine_q;
	coef_t k_cos;
	coef_t k_sin;
	coef_t k_nsin;
	lane_t pass_x;
	lane_t pass_y;
	lane_t pass_z;

	function automatic lane_t mix_lane(coord_t a_lo, coord_t a_hi, coord_t b_lo, coord_t b_hi,
		coef_t ka, coef_t kb);
		lane_t l;
		l.pass = 1'b0;
		l.a_lo = a_lo;
		l.a_hi = a_hi;
		l.b_lo = b_lo;
		l.b_hi = b_hi;
		l.ka   = ka;
		l.kb   = kb;
		return l;
	endfunction

	function automatic lane_t pass_lane(coord_t lo, coord_t hi);
		lane_t l;
		l.pass = 1'b1;
		l.a_lo = lo;
		l.a_hi = hi;
		l.b_lo = '0;
		l.b_hi = '0;
		l.ka   = '0;
		l.kb   = '0;
		return l;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q   <= AXIS_ROLL;
			sine_q   <= '0;
			cosine_q <= COSINE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_AXIS:   axis_q   <= axis_t'(cfg_data[1:0]);
				REG_SINE:   sine_q   <= cfg_data;
				REG_COSINE: cosine_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign k_cos  = KW'(cosine_q);
	assign k_sin  = KW'(sine_q);
	assign k_nsin = -k_sin;

	assign pass_x = pass_lane(box.low_x, box.high_x);
	assign pass_y = pass_lane(box.low_y, box.high_y);
	assign pass_z = pass_lane(box.low_z, box.high_z);

	always_comb begin
		entry.present = box.box_present;
		case (axis_q)
			AXIS_ROLL: begin
				entry.lane[0] = pass_x;
				entry.lane[1] = mix_lane(box.low_y, box.high_y, box.low_z, box.high_z,
					k_cos, k_sin);
				entry.lane[2] = mix_lane(box.low_y, box.high_y, box.low_z, box.high_z,
					k_nsin, k_cos);
			end
			AXIS_PITCH: begin
				entry.lane[0] = mix_lane(box.low_x, box.high_x, box.low_z, box.high_z,
					k_cos, k_sin);
				entry.lane[1] = pass_y;
				entry.lane[2] = mix_lane(box.low_x, box.high_x, box.low_z, box.high_z,
					k_nsin, k_cos);
			end
			AXIS_YAW: begin
				entry.lane[0] = mix_lane(box.low_x, box.high_x, box.low_y, box.high_y,
					k_cos, k_sin);
				entry.lane[1] = mix_lane(box.low_x, box.high_x, box.low_y, box.high_y,
					k_nsin, k_cos);
				entry.lane[2] = pass_z;
			end
			default: begin
				entry.lane[0] = pass_x;
				entry.lane[1] = pass_y;
				entry.lane[2] = pass_z;
			end
		endcase
	end

endmodule

@@ rtl/rbb_back.sv @@
module rbb_back import rbb_pkg::*; #(
	parameter int TRIG_FRACTION = TRIG_FRACTION_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  entry_t q_data,
	output logic   pop,
	output logic   bound_valid,
	input  logic   bound_stall,
	output bound_t bound
);

	localparam int PROD_W = COORD_W + KW;
	localparam int SH_W   = PROD_W - TRIG_FRACTION;
	localparam int EXT_W  = (SH_W > COORD_W) ? SH_W : COORD_W;
	localparam int SUM_W  = EXT_W + 1;

	localparam logic signed [SUM_W-1:0] HI_LIM =
		{{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] LO_LIM =
		{{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	logic   valid_s1;
	logic   valid_s2;
	logic   valid_s3;
	logic   present_s1;
	logic   present_s2;
	logic   en1;
	logic   en2;
	logic   en3;
	coord_t lo_sat [LANES];
	coord_t hi_sat [LANES];
	bound_t bound_s3;

	assign en3 = !valid_s3 || !bound_stall;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign pop = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= q_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			present_s1 <= q_data.present;
		end
		if (en2) begin
			present_s2 <= present_s1;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic signed [PROD_W-1:0] pa_lo_s1;
		logic signed [PROD_W-1:0] pa_hi_s1;
		logic signed [PROD_W-1:0] pb_lo_s1;
		logic signed [PROD_W-1:0] pb_hi_s1;
		coord_t                   c_lo_s1;
		coord_t                   c_hi_s1;
		logic                     pass_s1;
		logic signed [PROD_W-1:0] ta_lo;
		logic signed [PROD_W-1:0] ta_hi;
		logic signed [PROD_W-1:0] tb_lo;
		logic signed [PROD_W-1:0] tb_hi;
		logic signed [EXT_W-1:0]  ea_lo;
		logic signed [EXT_W-1:0]  ea_hi;
		logic signed [EXT_W-1:0]  eb_lo;
		logic signed [EXT_W-1:0]  eb_hi;
		logic signed [EXT_W-1:0]  ec_lo;
		logic signed [EXT_W-1:0]  ec_hi;
		logic signed [EXT_W-1:0]  min_a_s2;
		logic signed [EXT_W-1:0]  max_a_s2;
		logic signed [EXT_W-1:0]  min_b_s2;
		logic signed [EXT_W-1:0]  max_b_s2;
		logic signed [SUM_W-1:0]  sum_lo;
		logic signed [SUM_W-1:0]  sum_hi;

		always_ff @(posedge clk) begin
			if (en1) begin
				pa_lo_s1 <= PROD_W'($signed(q_data.lane[l].a_lo)) * PROD_W'($signed(q_data.lane[l].ka));
				pa_hi_s1 <= PROD_W'($signed(q_data.lane[l].a_hi)) * PROD_W'($signed(q_data.lane[l].ka));
				pb_lo_s1 <= PROD_W'($signed(q_data.lane[l].b_lo)) * PROD_W'($signed(q_data.lane[l].kb));
				pb_hi_s1 <= PROD_W'($signed(q_data.lane[l].b_hi)) * PROD_W'($signed(q_data.lane[l].kb));
				c_lo_s1  <= q_data.lane[l].a_lo;
				c_hi_s1  <= q_data.lane[l].a_hi;
				pass_s1  <= q_data.lane[l].pass;
			end
		end

		assign ta_lo = pa_lo_s1 >>> TRIG_FRACTION;
		assign ta_hi = pa_hi_s1 >>> TRIG_FRACTION;
		assign tb_lo = pb_lo_s1 >>> TRIG_FRACTION;
		assign tb_hi = pb_hi_s1 >>> TRIG_FRACTION;
		assign ea_lo = ta_lo[EXT_W-1:0];
		assign ea_hi = ta_hi[EXT_W-1:0];
		assign eb_lo = tb_lo[EXT_W-1:0];
		assign eb_hi = tb_hi[EXT_W-1:0];
		assign ec_lo = EXT_W'(c_lo_s1);
		assign ec_hi = EXT_W'(c_hi_s1);

		always_ff @(posedge clk) begin
			if (en2) begin
				if (pass_s1) begin
					min_a_s2 <= (ec_lo < ec_hi) ? ec_lo : ec_hi;
					max_a_s2 <= (ec_lo < ec_hi) ? ec_hi : ec_lo;
					min_b_s2 <= '0;
					max_b_s2 <= '0;
				end else begin
					min_a_s2 <= (ea_lo < ea_hi) ? ea_lo : ea_hi;
					max_a_s2 <= (ea_lo < ea_hi) ? ea_hi : ea_lo;
					min_b_s2 <= (eb_lo < eb_hi) ? eb_lo : eb_hi;
					max_b_s2 <= (eb_lo < eb_hi) ? eb_hi : eb_lo;
				end
			end
		end

		assign sum_lo = SUM_W'(min_a_s2) + SUM_W'(min_b_s2);
		assign sum_hi = SUM_W'(max_a_s2) + SUM_W'(max_b_s2);

		always_comb begin
			if (sum_lo > HI_LIM) begin
				lo_sat[l] = COORD_MAX;
			end else if (sum_lo < LO_LIM) begin
				lo_sat[l] = COORD_MIN;
			end else begin
				lo_sat[l] = sum_lo[COORD_W-1:0];
			end
			if (sum_hi > HI_LIM) begin
				hi_sat[l] = COORD_MAX;
			end else if (sum_hi < LO_LIM) begin
				hi_sat[l] = COORD_MIN;
			end else begin
				hi_sat[l] = sum_hi[COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			if (present_s2) begin
				bound_s3.result_present <= 1'b1;
				bound_s3.bound_low_x    <= lo_sat[0];
				bound_s3.bound_low_y    <= lo_sat[1];
				bound_s3.bound_low_z    <= lo_sat[2];
				bound_s3.bound_high_x   <= hi_sat[0];
				bound_s3.bound_high_y   <= hi_sat[1];
				bound_s3.bound_high_z   <= hi_sat[2];
			end else begin
				bound_s3 <= '0;
			end
		end
	end

	assign bound_valid = valid_s3;
	assign bound       = bound_s3;

endmodule

@@ rtl/rotated_box_bounds.sv @@
// Bounding box of an axis-aligned box turned by the inverse of a rotation about
// x (roll), y (pitch) or z (yaw), with sine and cosine written as signed Q1.14
// through the configuration port (index 0 axis, 1 sine, 2 cosine; axis code 3
// means no rotation). Coordinates are signed Q16.16; each product is truncated
// toward minus infinity and each sum saturates. A request with box_present low
// returns a result with every field zero. While bound_stall stays low, one box is
// taken per clock cycle and one result leaves per cycle. A box passes through
// the two-entry queue, which registers it even when empty, then the multiply
// stage, the shift and min/max stage, and the add and saturate stage into the
// output register. The back end has twelve coordinate-by-trig multipliers,
// four per lane.
// Write configuration only while no request is in flight.
module rotated_box_bounds import rbb_pkg::*; #(
	parameter int TRIG_FRACTION = TRIG_FRACTION_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  box_valid,
	output logic                  box_stall,
	input  box_t                  box,
	output logic                  bound_valid,
	input  logic                  bound_stall,
	output bound_t                bound
);

	localparam int ENTRY_W = $bits(entry_t);

	entry_t             front_entry;
	entry_t             q_data;
	logic [ENTRY_W-1:0] q_vec;
	logic               q_full;
	logic               q_valid;
	logic               q_pop;

	rbb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.box       (box),
		.entry     (front_entry)
	);

	rbb_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (box_valid),
		.push_data (front_entry),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_vec),
		.not_empty (q_valid)
	);

	assign box_stall = q_full;
	assign q_data    = entry_t'(q_vec);

	rbb_back #(
		.TRIG_FRACTION (TRIG_FRACTION)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.pop         (q_pop),
		.bound_valid (bound_valid),
		.bound_stall (bound_stall),
		.bound       (bound)
	);

endmodule

@@ dv/rotated_box_bounds_tb.sv @@
`timescale 1ns / 1ps

module rotated_box_bounds_tb;
	import rbb_pkg::*;

	localparam longint COORD_TOP_L = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint COORD_BOT_L = -COORD_TOP_L - 1;
	localparam coord_t COORD_TOP   = coord_t'(COORD_TOP_L);
	localparam coord_t COORD_BOT   = coord_t'(COORD_BOT_L);
	localparam int     HOLD_LEN    = 300;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BEAT
	} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  box_valid = 1'b0;
	logic                  box_stall;
	box_t                  box = '0;
	logic                  bound_valid;
	logic                  bound_stall = 1'b0;
	bound_t                bound;

	axis_t  axis_reg = AXIS_ROLL;
	trig_t  sine_reg = '0;
	trig_t  cosine_reg = COSINE_RESET;

	box_t   boxes_waiting[$];
	bound_t bounds_due[$];

	bit          quiet_sender = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          boxes_taken = 0;
	int          absent_taken = 0;
	int          bounds_seen = 0;
	int          faults = 0;
	int          settings_run = 1;
	int          hold_left = 0;
	int          holds_done = 0;
	int          next_hold = 400;
	int          window_left = 0;
	int          beat = 0;
	stall_mode_t stall_mode = STALL_NONE;

	rotated_box_bounds i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.box_valid   (box_valid),
		.box_stall   (box_stall),
		.box         (box),
		.bound_valid (bound_valid),
		.bound_stall (bound_stall),
		.bound       (bound)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint turn_pair(longint a, longint b, longint ka, longint kb);
		longint sum;
		sum = ((a * ka) >>> TRIG_FRACTION_DEF) + ((b * kb) >>> TRIG_FRACTION_DEF);
		if (sum > COORD_TOP_L)
			return COORD_TOP_L;
		if (sum < COORD_BOT_L)
			return COORD_BOT_L;
		return sum;
	endfunction

	function automatic bound_t rotated_bounds(box_t b);
		bound_t r;
		longint lo[3], hi[3], p[3], q[3], mn[3], mx[3];
		longint s, c;
		r = '0;
		if (!b.box_present)
			return r;
		lo = '{b.low_x, b.low_y, b.low_z};
		hi = '{b.high_x, b.high_y, b.high_z};
		s = sine_reg;
		c = cosine_reg;
		for (int a = 0; a < 3; a++) begin
			mn[a] = COORD_TOP_L;
			mx[a] = COORD_BOT_L;
		end
		for (int n = 0; n < 8; n++) begin
			p[0] = n[2] ? hi[0] : lo[0];
			p[1] = n[1] ? hi[1] : lo[1];
			p[2] = n[0] ? hi[2] : lo[2];
			q = p;
			case (axis_reg)
			AXIS_ROLL: begin
				q[1] = turn_pair(p[1], p[2], c, s);
				q[2] = turn_pair(p[1], p[2], -s, c);
			end
			AXIS_PITCH: begin
				q[0] = turn_pair(p[0], p[2], c, s);
				q[2] = turn_pair(p[0], p[2], -s, c);
			end
			AXIS_YAW: begin
				q[0] = turn_pair(p[0], p[1], c, s);
				q[1] = turn_pair(p[0], p[1], -s, c);
			end
			default: ;
			endcase
			for (int a = 0; a < 3; a++) begin
				if (q[a] < mn[a])
					mn[a] = q[a];
				if (q[a] > mx[a])
					mx[a] = q[a];
			end
		end
		r.result_present = 1'b1;
		r.bound_low_x    = coord_t'(mn[0]);
		r.bound_low_y    = coord_t'(mn[1]);
		r.bound_low_z    = coord_t'(mn[2]);
		r.bound_high_x   = coord_t'(mx[0]);
		r.bound_high_y   = coord_t'(mx[1]);
		r.bound_high_z   = coord_t'(mx[2]);
		return r;
	endfunction

	function automatic string show_bounds(bound_t b);
		return $sformatf("present=%0b low=(%0d,%0d,%0d) high=(%0d,%0d,%0d)",
			b.result_present, b.bound_low_x, b.bound_low_y, b.bound_low_z,
			b.bound_high_x, b.bound_high_y, b.bound_high_z);
	endfunction

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 9))
		0: return COORD_TOP;
		1: return COORD_BOT;
		2, 3, 4: return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
		default: return coord_t'($urandom());
		endcase
	endfunction

	function automatic box_t random_box();
		box_t   b;
		coord_t u[3], v[3];
		for (int a = 0; a < 3; a++) begin
			u[a] = pick_coord();
			v[a] = pick_coord();
			if ($urandom_range(0, 6) != 0 && u[a] > v[a]) begin
				u[a] = v[a];
				v[a] = pick_coord();
				if (v[a] < u[a])
					v[a] = COORD_TOP;
			end
		end
		b.box_present = ($urandom_range(0, 9) != 0);
		b.low_x  = u[0];
		b.low_y  = u[1];
		b.low_z  = u[2];
		b.high_x = v[0];
		b.high_y = v[1];
		b.high_z = v[2];
		return b;
	endfunction

	function automatic box_t make_box(bit present, coord_t lo, coord_t hi);
		return '{present, lo, lo, lo, hi, hi, hi};
	endfunction

	task automatic queue_corner_boxes();
		boxes_waiting.push_back(make_box(1'b0, '1, '1));
		boxes_waiting.push_back(random_box() & ~(box_t'(1) << ($bits(box_t) - 1)));
		boxes_waiting.push_back(make_box(1'b1, '0, '0));
		boxes_waiting.push_back(make_box(1'b1, COORD_TOP, COORD_TOP));
		boxes_waiting.push_back(make_box(1'b1, COORD_BOT, COORD_BOT));
		boxes_waiting.push_back(make_box(1'b1, COORD_BOT, COORD_TOP));
		boxes_waiting.push_back(make_box(1'b1, COORD_TOP, COORD_BOT));
		boxes_waiting.push_back(make_box(1'b1, -1, 1));
		boxes_waiting.push_back(make_box(1'b1, '0, 32'h0001_0000));
		boxes_waiting.push_back('{1'b1, -32'sh0003_0000, 32'sh0002_8000, -32'sh0000_4000,
			32'sh0001_0000, -32'sh0001_0000, 32'sh7000_0000});
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		REG_AXIS:   axis_reg = axis_t'(val[1:0]);
		REG_SINE:   sine_reg = trig_t'(val);
		REG_COSINE: cosine_reg = trig_t'(val);
		default: ;
		endcase
	endtask

	task automatic drain();
		while (boxes_waiting.size() != 0 || box_valid || bounds_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_setting(input axis_t ax, input trig_t s, input trig_t c,
			input bit corners, input bit steady);
		write_reg(REG_AXIS, CFG_DATA_W'(ax));
		write_reg(REG_SINE, s);
		write_reg(REG_COSINE, c);
		settings_run++;
		quiet_sender = steady;
		if (corners)
			queue_corner_boxes();
		repeat (110) boxes_waiting.push_back(random_box());
		drain();
	endtask

	// driver: one request per cycle in bursts while box_stall is low, gaps suppressed while the receiver holds off
	always @(posedge clk) begin
		if (arst_n) begin
			if (box_valid && !box_stall) begin
				bounds_due.push_back(rotated_bounds(box));
				boxes_taken <= boxes_taken + 1;
				if (!box.box_present)
					absent_taken <= absent_taken + 1;
			end
			if (box_valid && box_stall) begin
			end else if (gap_left != 0 && hold_left == 0) begin
				box_valid <= 1'b0;
				gap_left  <= gap_left - 1;
			end else if (boxes_waiting.size() != 0) begin
				box       <= boxes_waiting.pop_front();
				box_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= (quiet_sender || $urandom_range(0, 2) == 0) ? 0 :
						$urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				box_valid <= 1'b0;
			end
		end
	end

	// receiver: windows of stall modes, plus two long hold-offs
	always @(posedge clk) begin
		if (arst_n) begin
			beat <= beat + 1;
			if (hold_left != 0) begin
				bound_stall <= 1'b1;
				hold_left   <= hold_left - 1;
			end else if (holds_done < 2 && boxes_taken >= next_hold) begin
				bound_stall <= 1'b1;
				hold_left   <= HOLD_LEN;
				holds_done  <= holds_done + 1;
				next_hold   <= next_hold + 600;
			end else begin
				if (window_left == 0) begin
					stall_mode  <= stall_mode_t'($urandom_range(0, 3));
					window_left <= $urandom_range(20, 120);
				end else begin
					window_left <= window_left - 1;
				end
				case (stall_mode)
				STALL_NONE:  bound_stall <= 1'b0;
				STALL_LIGHT: bound_stall <= ($urandom_range(0, 9) < 3);
				STALL_HEAVY: bound_stall <= ($urandom_range(0, 9) < 7);
				default:     bound_stall <= (beat % 3 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		bound_t want;
		if (arst_n && bound_valid && !bound_stall) begin
			if (bounds_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected bounds: %s", show_bounds(bound));
			end else begin
				want = bounds_due.pop_front();
				bounds_seen++;
				if (bound !== want) begin
					faults++;
					if (faults <= 10) begin
						$display("bounds mismatch on result %0d", bounds_seen);
						$display("  want %s", show_bounds(want));
						$display("  got  %s", show_bounds(bound));
					end
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL rotated_box_bounds");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings first, no register written yet
		queue_corner_boxes();
		repeat (110) boxes_waiting.push_back(random_box());
		drain();

		run_setting(AXIS_YAW, 16'sd11585, 16'sd11585, 1'b0, 1'b1);
		run_setting(AXIS_ROLL, 16'sd16384, 16'sd0, 1'b0, 1'b0);
		run_setting(AXIS_PITCH, -16'sd16384, -16'sd16384, 1'b0, 1'b1);
		run_setting(AXIS_NONE, 16'sd12345, -16'sd2222, 1'b0, 1'b0);
		run_setting(AXIS_YAW, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
		run_setting(AXIS_ROLL, 16'sh7FFF, 16'sh8000, 1'b0, 1'b1);
		run_setting(AXIS_PITCH, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
		run_setting(AXIS_YAW, 16'sh8000, 16'sh8000, 1'b0, 1'b0);
		repeat (5) begin
			if ($urandom_range(0, 1) == 0)
				run_setting(axis_t'($urandom_range(0, 2)),
					trig_t'(int'($urandom_range(0, 32768)) - 16384),
					trig_t'(int'($urandom_range(0, 32768)) - 16384), 1'b0, $urandom_range(0, 1));
			else
				run_setting(axis_t'($urandom_range(0, 3)), trig_t'($urandom()),
					trig_t'($urandom()), 1'b0, $urandom_range(0, 1));
		end

		repeat (20) @(posedge clk);
		$display("ran %0d boxes (%0d absent) over %0d rotation settings, %0d long hold-offs",
			boxes_taken, absent_taken, settings_run, holds_done);
		$display("checked %0d results, %0d faults", bounds_seen, faults);
		if (faults == 0 && bounds_due.size() == 0)
			$display("PASS rotated_box_bounds");
		else
			$display("FAIL rotated_box_bounds");
		$finish;
	end

endmodule
